// ----- src/iirl_pkg.sv -----
// Shared types and constants for the indexed insert/remove list.
package iirl_pkg;

   localparam int OPCODE_W = 3;
   localparam int POS_W    = 8;
   localparam int VALUE_W  = 64;
   localparam int STATUS_W = 2;
   localparam int ICOUNT_W = 5;

   localparam logic [OPCODE_W-1:0] OP_GET    = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_SET    = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic               write;
      logic               shift_up;
      logic               shift_down;
      logic [POS_W-1:0]   pos;
      logic [VALUE_W-1:0] value;
   } cell_cmd_type;

endpackage

// ----- src/iirl_req_if.sv -----
// Request channel carrying one list operation per item.
interface iirl_req_if;
   import iirl_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [POS_W-1:0]    position;
   logic [VALUE_W-1:0]  value_in;

   modport source (output valid, output opcode, output position, output value_in,
                   input ready);
   modport sink   (input valid, input opcode, input position, input value_in,
                   output ready);
endinterface

// ----- src/iirl_rsp_if.sv -----
// Response channel carrying one result item per operation.
interface iirl_rsp_if;
   import iirl_pkg::*;

   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  value_out;
   logic [STATUS_W-1:0] status;
   logic [ICOUNT_W-1:0] item_count;

   modport source (output valid, output value_out, output status, output item_count,
                   input ready);
   modport sink   (input valid, input value_out, input status, input item_count,
                   output ready);
endinterface

// ----- src/indexed_insert_remove_list_core.sv -----
// Top level of the indexed insert/remove list: decode, count and the row of slots.
module indexed_insert_remove_list_core #(
   parameter int CAPACITY = 16
) (
   input  logic  clock,
   input  logic  reset,
   iirl_req_if.sink   req_ch,
   iirl_rsp_if.source rsp_ch
);
   import iirl_pkg::*;

   // Ordered list of CAPACITY 64-bit entries held in a row of slots. A request item is
   // accepted whenever the result register is empty or its item is being taken, and its
   // result appears in the next cycle. An insert or remove moves every slot above the
   // position by one place in that same cycle, so a new item can follow every cycle
   // while the response side takes results. Reset clears the count and empties the result
   // register; entries hold no value until written.

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [VALUE_W-1:0]  value_out_ff;
   logic [VALUE_W-1:0]  value_out_in;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   logic [ICOUNT_W-1:0] item_count_ff;
   logic [ICOUNT_W-1:0] item_count_in;

   logic                accept;
   logic [CMP_W-1:0]    pos_c;
   logic [CMP_W-1:0]    cnt_c;
   logic                in_range;
   logic                fits;
   logic                full;
   logic [VALUE_W-1:0]  read_value;
   cell_cmd_type        cmd;

   logic [VALUE_W-1:0]  cell_entry [CAPACITY];
   logic [VALUE_W-1:0]  cell_read  [CAPACITY];

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign pos_c    = CMP_W'(req_ch.position);
   assign cnt_c    = CMP_W'(count_ff);
   assign in_range = pos_c < cnt_c;
   assign fits     = pos_c <= cnt_c;
   assign full     = cnt_c == CMP_W'(CAPACITY);

   always_comb begin
      read_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_value = read_value | cell_read[i];
      end
   end

   always_comb begin
      cmd            = '0;
      cmd.pos        = req_ch.position;
      cmd.value      = req_ch.value_in;
      count_in       = count_ff;
      value_out_in   = '0;
      status_in      = ST_OK;
      unique case (req_ch.opcode)
         OP_GET: begin
            if (in_range) begin
               value_out_in = read_value;
            end else begin
               status_in = ST_RANGE;
            end
         end
         OP_SET: begin
            if (in_range) begin
               cmd.write = accept;
            end else begin
               status_in = ST_RANGE;
            end
         end
         OP_INSERT: begin
            if (!fits) begin
               status_in = ST_RANGE;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.shift_up = accept;
               count_in     = count_ff + CNT_W'(1);
            end
         end
         OP_REMOVE: begin
            if (in_range) begin
               value_out_in   = read_value;
               cmd.shift_down = accept;
               count_in       = count_ff - CNT_W'(1);
            end else begin
               status_in = ST_RANGE;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
      item_count_in = ICOUNT_W'(count_in);
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         value_out_ff  <= value_out_in;
         status_ff     <= status_in;
         item_count_ff <= item_count_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.value_out  = value_out_ff;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.item_count = item_count_ff;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [VALUE_W-1:0] left_data;
      logic [VALUE_W-1:0] right_data;

      if (g == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_mid_left
         assign left_data = cell_entry[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_mid_right
         assign right_data = cell_entry[g+1];
      end

      iirl_cell #(
         .CELL_INDEX (g)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_data  (left_data),
         .right_data (right_data),
         .entry      (cell_entry[g]),
         .read_data  (cell_read[g])
      );
   end

endmodule

// ----- src/iirl_cell.sv -----
// One list slot that holds an entry and trades it with its neighbors.
module iirl_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                           clock,
   input  iirl_pkg::cell_cmd_type         cmd,
   input  logic [iirl_pkg::VALUE_W-1:0]   left_data,
   input  logic [iirl_pkg::VALUE_W-1:0]   right_data,
   output logic [iirl_pkg::VALUE_W-1:0]   entry,
   output logic [iirl_pkg::VALUE_W-1:0]   read_data
);
   import iirl_pkg::*;

   localparam logic [POS_W-1:0] IDX = POS_W'(CELL_INDEX);

   logic [VALUE_W-1:0] entry_ff;
   logic [VALUE_W-1:0] entry_in;
   logic               hit;
   logic               above;

   assign hit   = (cmd.pos == IDX);
   assign above = (IDX > cmd.pos);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.write && hit) begin
         entry_in = cmd.value;
      end else if (cmd.shift_up) begin
         if (hit) begin
            entry_in = cmd.value;
         end else if (above) begin
            entry_in = left_data;
         end
      end else if (cmd.shift_down && (hit || above)) begin
         entry_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry     = entry_ff;
   assign read_data = hit ? entry_ff : '0;

endmodule
